/* design/cave_grid_smooth_and_region_filter_defines.svh */
// Assertion macros shared by the checker.
`ifndef CAVE_GRID_SMOOTH_AND_REGION_FILTER_DEFINES_SVH
`define CAVE_GRID_SMOOTH_AND_REGION_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGSRF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgsrf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CGSRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgsrf assertion failed");

`endif

/* design/cgsrf_pkg.sv */
`timescale 1ns / 1ps
package cgsrf_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Operation codes of an input word.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SMOOTH      = 3'd2;
  localparam logic [2:0] REG_NB_LIMIT    = 3'd3;
  localparam logic [2:0] REG_ROOM_MIN    = 3'd4;
  localparam logic [2:0] REG_WALL_MIN    = 3'd5;

  // Bit positions inside one cell memory entry.
  localparam int GRID_B = 0;
  localparam int VIS_B  = 1;
  localparam int FLIP_B = 2;
  localparam int CELL_DW = 3;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SM_RD,
    ST_SM_WR,
    ST_SC_RD,
    ST_SC_CHK,
    ST_BF_POP,
    ST_BF_POPW,
    ST_BF_NB,
    ST_BF_NBW,
    ST_MK_RD,
    ST_MK_CELL,
    ST_MK_WR,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Offsets of the eight neighbours as {row code, column code}; code 0 is -1,
  // 1 is 0 and 2 is +1.
  function automatic logic [3:0] nb_off(input logic [2:0] idx);
    logic [3:0] o;
    case (idx)
      3'd0: o = {2'd0, 2'd0};
      3'd1: o = {2'd0, 2'd1};
      3'd2: o = {2'd0, 2'd2};
      3'd3: o = {2'd1, 2'd0};
      3'd4: o = {2'd1, 2'd2};
      3'd5: o = {2'd2, 2'd0};
      3'd6: o = {2'd2, 2'd1};
      default: o = {2'd2, 2'd2};
    endcase
    return o;
  endfunction

endpackage

/* design/cgsrf_ram.sv */
`timescale 1ns / 1ps
module cgsrf_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 3
) (
  input  logic               clk,
  input  cgsrf_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [DW-1:0]      wdata,
  input  logic [AW-1:0]      raddr,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/cave_grid_smooth_and_region_filter.sv */
`timescale 1ns / 1ps
// Cave grid smoother and region filter. The grid of MAX_COLS by MAX_ROWS cells
// lives in a simple dual-port cell memory (grid, visited and flip bits per
// cell) next to a flood-fill queue memory; both have a registered read. A
// write word leaves the block idle and a new word may follow at once. A read
// word passes the cell memory read register and the READ state before its
// result sits in the output register. A run word walks the grid with one
// shared sequencer: every smoothing pass does eight neighbour reads per
// interior cell and writes it back unless its count equals the limit, the
// region search reads each cell and each queued neighbour and marks every
// cell of a region that is too small, and the closing apply sweep reads and
// writes back every cell. After reset the block clears every cell memory entry
// and accepts no word meanwhile; configuration writes are taken at any time.
module cave_grid_smooth_and_region_filter #(
  parameter int MAX_COLS = cgsrf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = cgsrf_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [5:0]  in_col,
  input  logic [5:0]  in_row,
  input  logic        in_cell_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_cell_out,
  output logic        out_run_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int QW    = AW + 1;
  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int DW    = cgsrf_pkg::CELL_DW;

  // Configuration registers.
  logic [6:0]  grid_width_r, grid_height_r;
  logic [3:0]  smooth_passes_r, neighbour_limit_r;
  logic [12:0] room_min_size_r, wall_min_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r      <= 7'd64;
      grid_height_r     <= 7'd64;
      smooth_passes_r   <= '0;
      neighbour_limit_r <= '0;
      room_min_size_r   <= '0;
      wall_min_size_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cgsrf_pkg::REG_GRID_WIDTH:  grid_width_r      <= cfg_data[6:0];
        cgsrf_pkg::REG_GRID_HEIGHT: grid_height_r     <= cfg_data[6:0];
        cgsrf_pkg::REG_SMOOTH:      smooth_passes_r   <= cfg_data[3:0];
        cgsrf_pkg::REG_NB_LIMIT:    neighbour_limit_r <= cfg_data[3:0];
        cgsrf_pkg::REG_ROOM_MIN:    room_min_size_r   <= cfg_data;
        cgsrf_pkg::REG_WALL_MIN:    wall_min_size_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Active dimensions, saturated to the storage.
  logic [9:0] w_sat, h_sat, w_last, h_last;
  assign w_sat  = (10'(grid_width_r) > 10'(MAX_COLS)) ? 10'(MAX_COLS) : 10'(grid_width_r);
  assign h_sat  = (10'(grid_height_r) > 10'(MAX_ROWS)) ? 10'(MAX_ROWS) : 10'(grid_height_r);
  assign w_last = w_sat - 10'd2;
  assign h_last = h_sat - 10'd2;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  // Sequencer registers.
  cgsrf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] c_r, c_nxt, pc_r, pc_nxt;
  logic [RW-1:0] r_r, r_nxt, pr_r, pr_nxt;
  logic [3:0]    pass_r, pass_nxt, ni_r, ni_nxt, cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt, val_r, val_nxt, rd_in_r, rd_in_nxt;
  logic [1:0]    dir_r, dir_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt, idx_r, idx_nxt;
  logic [QW-1:0] sw_r, sw_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          out_valid_r, out_valid_nxt, out_cell_r, out_cell_nxt;
  logic          out_done_r, out_done_nxt;

  // Memory ports.
  cgsrf_pkg::mem_ctl_t cell_ctl, q_ctl;
  logic [AW-1:0]       cell_waddr, cell_raddr, q_waddr, q_raddr;
  logic [DW-1:0]       cell_wdata, cell_rdata;
  logic [RW+CW-1:0]    q_wdata, q_rdata;

  cgsrf_ram #(.DEPTH(CELLS), .AW(AW), .DW(DW)) u_cell_ram (
    .clk(clk), .ctl(cell_ctl), .waddr(cell_waddr), .wdata(cell_wdata),
    .raddr(cell_raddr), .rdata(cell_rdata)
  );

  cgsrf_ram #(.DEPTH(CELLS), .AW(AW), .DW(RW + CW)) u_queue_ram (
    .clk(clk), .ctl(q_ctl), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  // Shared conditions.
  logic in_acc, in_inside, out_free, small_grid;
  logic [CW-1:0] in_c;
  logic [RW-1:0] in_r;
  assign in_acc     = in_valid && !in_stall;
  assign in_inside  = (9'(in_col) < 9'(MAX_COLS)) && (9'(in_row) < 9'(MAX_ROWS));
  assign in_c       = CW'(in_col);
  assign in_r       = RW'(in_row);
  assign out_free   = !out_valid_r || !out_stall;
  assign small_grid = (w_sat < 10'd3) || (h_sat < 10'd3);

  // Raster stepping (column outer, row inner) over the interior.
  logic last_r, last_c, last_pass;
  assign last_r    = (10'(r_r) == h_last);
  assign last_c    = (10'(c_r) == w_last);
  assign last_pass = (pass_r + 4'd1 == smooth_passes_r);

  // Smoothing neighbour of the current cell.
  logic [3:0]    off;
  logic [CW-1:0] sm_c;
  logic [RW-1:0] sm_r;
  logic [3:0]    nsum;
  assign off  = cgsrf_pkg::nb_off(ni_r[2:0]);
  assign sm_c = CW'(10'(c_r) + 10'(off[1:0]) - 10'd1);
  assign sm_r = RW'(10'(r_r) + 10'(off[3:2]) - 10'd1);
  assign nsum = cnt_r + 4'(cell_rdata[cgsrf_pkg::GRID_B]);

  // Flood-fill neighbour of the popped cell.
  logic [9:0]    nb_c10, nb_r10;
  logic          nb_ok;
  logic [CW-1:0] nb_c;
  logic [RW-1:0] nb_r;
  always_comb begin
    nb_c10 = 10'(pc_r);
    nb_r10 = 10'(pr_r);
    case (dir_r)
      2'd0:    nb_c10 = 10'(pc_r) - 10'd1;
      2'd1:    nb_c10 = 10'(pc_r) + 10'd1;
      2'd2:    nb_r10 = 10'(pr_r) - 10'd1;
      default: nb_r10 = 10'(pr_r) + 10'd1;
    endcase
  end
  assign nb_ok = (nb_c10 >= 10'd1) && (nb_c10 <= w_last) &&
                 (nb_r10 >= 10'd1) && (nb_r10 <= h_last);
  assign nb_c  = CW'(nb_c10);
  assign nb_r  = RW'(nb_r10);

  logic nb_join, small_region;
  logic [13:0] limit;
  assign nb_join      = (cell_rdata[cgsrf_pkg::GRID_B] == val_r) &&
                        !cell_rdata[cgsrf_pkg::VIS_B];
  assign limit        = val_r ? 14'(room_min_size_r) : 14'(wall_min_size_r);
  assign small_region = (14'(tail_r) < limit);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cgsrf_pkg::ST_CLEAR: begin
        if (sw_r == QW'(CELLS - 1)) begin
          state_nxt = cgsrf_pkg::ST_IDLE;
        end
      end
      cgsrf_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            cgsrf_pkg::OP_READ: state_nxt = cgsrf_pkg::ST_READ;
            cgsrf_pkg::OP_RUN: begin
              if (small_grid) begin
                state_nxt = cgsrf_pkg::ST_DONE;
              end else if (smooth_passes_r != 4'd0) begin
                state_nxt = cgsrf_pkg::ST_SM_RD;
              end else begin
                state_nxt = cgsrf_pkg::ST_SC_RD;
              end
            end
            default: ;
          endcase
        end
      end
      cgsrf_pkg::ST_READ: begin
        if (out_free) begin
          state_nxt = cgsrf_pkg::ST_IDLE;
        end
      end
      cgsrf_pkg::ST_SM_RD: begin
        if (ni_r == 4'd7) begin
          state_nxt = cgsrf_pkg::ST_SM_WR;
        end
      end
      cgsrf_pkg::ST_SM_WR: begin
        if (last_r && last_c && last_pass) begin
          state_nxt = cgsrf_pkg::ST_SC_RD;
        end else begin
          state_nxt = cgsrf_pkg::ST_SM_RD;
        end
      end
      cgsrf_pkg::ST_SC_RD: state_nxt = cgsrf_pkg::ST_SC_CHK;
      cgsrf_pkg::ST_SC_CHK: begin
        if (!cell_rdata[cgsrf_pkg::VIS_B]) begin
          state_nxt = cgsrf_pkg::ST_BF_POP;
        end else if (last_r && last_c) begin
          state_nxt = cgsrf_pkg::ST_APPLY;
        end else begin
          state_nxt = cgsrf_pkg::ST_SC_RD;
        end
      end
      cgsrf_pkg::ST_BF_POP: begin
        if (head_r < tail_r) begin
          state_nxt = cgsrf_pkg::ST_BF_POPW;
        end else if (small_region) begin
          state_nxt = cgsrf_pkg::ST_MK_RD;
        end else if (last_r && last_c) begin
          state_nxt = cgsrf_pkg::ST_APPLY;
        end else begin
          state_nxt = cgsrf_pkg::ST_SC_RD;
        end
      end
      cgsrf_pkg::ST_BF_POPW: state_nxt = cgsrf_pkg::ST_BF_NB;
      cgsrf_pkg::ST_BF_NB: begin
        if (nb_ok) begin
          state_nxt = cgsrf_pkg::ST_BF_NBW;
        end else if (dir_r == 2'd3) begin
          state_nxt = cgsrf_pkg::ST_BF_POP;
        end
      end
      cgsrf_pkg::ST_BF_NBW: begin
        state_nxt = (dir_r == 2'd3) ? cgsrf_pkg::ST_BF_POP : cgsrf_pkg::ST_BF_NB;
      end
      cgsrf_pkg::ST_MK_RD: begin
        if (idx_r < tail_r) begin
          state_nxt = cgsrf_pkg::ST_MK_CELL;
        end else if (last_r && last_c) begin
          state_nxt = cgsrf_pkg::ST_APPLY;
        end else begin
          state_nxt = cgsrf_pkg::ST_SC_RD;
        end
      end
      cgsrf_pkg::ST_MK_CELL: state_nxt = cgsrf_pkg::ST_MK_WR;
      cgsrf_pkg::ST_MK_WR:   state_nxt = cgsrf_pkg::ST_MK_RD;
      cgsrf_pkg::ST_APPLY: begin
        if (sw_r == QW'(CELLS) && !pend_r) begin
          state_nxt = cgsrf_pkg::ST_DONE;
        end
      end
      cgsrf_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cgsrf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cgsrf_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory requests and outputs.
  always_comb begin
    c_nxt = c_r;       r_nxt = r_r;       pc_nxt = pc_r;     pr_nxt = pr_r;
    pass_nxt = pass_r; ni_nxt = ni_r;     cnt_nxt = cnt_r;   pend_nxt = pend_r;
    val_nxt = val_r;   rd_in_nxt = rd_in_r; dir_nxt = dir_r;
    head_nxt = head_r; tail_nxt = tail_r; idx_nxt = idx_r;
    sw_nxt = sw_r;     wa_nxt = wa_r;
    out_cell_nxt = out_cell_r; out_done_nxt = out_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    cell_ctl = '0;     q_ctl = '0;
    cell_waddr = '0;   cell_raddr = '0;   cell_wdata = '0;
    q_waddr = '0;      q_raddr = '0;      q_wdata = '0;

    unique case (state_r)
      cgsrf_pkg::ST_CLEAR: begin
        cell_ctl.we = 1'b1;
        cell_waddr  = sw_r[AW-1:0];
        sw_nxt      = sw_r + QW'(1);
      end
      cgsrf_pkg::ST_IDLE: begin
        if (in_acc) begin
          c_nxt = CW'(1); r_nxt = RW'(1); pass_nxt = '0;
          ni_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
          rd_in_nxt = in_inside;
          case (in_op)
            cgsrf_pkg::OP_WRITE: begin
              cell_ctl.we = in_inside;
              cell_waddr  = cell_addr(in_c, in_r);
              cell_wdata[cgsrf_pkg::GRID_B] = in_cell_in;
            end
            cgsrf_pkg::OP_READ: begin
              cell_ctl.re = in_inside;
              cell_raddr  = cell_addr(in_c, in_r);
            end
            default: ;
          endcase
        end
      end
      cgsrf_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = rd_in_r && cell_rdata[cgsrf_pkg::GRID_B];
          out_done_nxt  = 1'b0;
        end
      end
      cgsrf_pkg::ST_SM_RD: begin
        cell_ctl.re = 1'b1;
        cell_raddr  = cell_addr(sm_c, sm_r);
        if (pend_r) begin
          cnt_nxt = nsum;
        end
        pend_nxt = 1'b1;
        ni_nxt   = ni_r + 4'd1;
      end
      cgsrf_pkg::ST_SM_WR: begin
        // Cells at exactly the limit keep their value and are not written.
        cell_waddr = cell_addr(c_r, r_r);
        if (nsum > neighbour_limit_r) begin
          cell_ctl.we = 1'b1;
          cell_wdata[cgsrf_pkg::GRID_B] = 1'b1;
        end else if (nsum < neighbour_limit_r) begin
          cell_ctl.we = 1'b1;
        end
        ni_nxt = '0; cnt_nxt = '0; pend_nxt = 1'b0;
        if (!last_r) begin
          r_nxt = r_r + RW'(1);
        end else begin
          r_nxt = RW'(1);
          if (!last_c) begin
            c_nxt = c_r + CW'(1);
          end else begin
            c_nxt    = CW'(1);
            pass_nxt = pass_r + 4'd1;
          end
        end
      end
      cgsrf_pkg::ST_SC_RD: begin
        cell_ctl.re = 1'b1;
        cell_raddr  = cell_addr(c_r, r_r);
      end
      cgsrf_pkg::ST_SC_CHK: begin
        if (!cell_rdata[cgsrf_pkg::VIS_B]) begin
          // A new region starts here: mark the seed and queue it.
          val_nxt     = cell_rdata[cgsrf_pkg::GRID_B];
          cell_ctl.we = 1'b1;
          cell_waddr  = cell_addr(c_r, r_r);
          cell_wdata  = cell_rdata;
          cell_wdata[cgsrf_pkg::VIS_B] = 1'b1;
          q_ctl.we    = 1'b1;
          q_waddr     = '0;
          q_wdata     = {r_r, c_r};
          head_nxt    = '0;
          tail_nxt    = QW'(1);
        end else if (!last_r) begin
          r_nxt = r_r + RW'(1);
        end else if (!last_c) begin
          r_nxt = RW'(1);
          c_nxt = c_r + CW'(1);
        end else begin
          sw_nxt = '0; pend_nxt = 1'b0;
        end
      end
      cgsrf_pkg::ST_BF_POP: begin
        if (head_r < tail_r) begin
          q_ctl.re = 1'b1;
          q_raddr  = head_r[AW-1:0];
          head_nxt = head_r + QW'(1);
        end else if (small_region) begin
          idx_nxt = '0;
        end else if (!last_r) begin
          r_nxt = r_r + RW'(1);
        end else if (!last_c) begin
          r_nxt = RW'(1);
          c_nxt = c_r + CW'(1);
        end else begin
          sw_nxt = '0; pend_nxt = 1'b0;
        end
      end
      cgsrf_pkg::ST_BF_POPW: begin
        pc_nxt  = q_rdata[CW-1:0];
        pr_nxt  = q_rdata[RW+CW-1:CW];
        dir_nxt = 2'd0;
      end
      cgsrf_pkg::ST_BF_NB: begin
        if (nb_ok) begin
          cell_ctl.re = 1'b1;
          cell_raddr  = cell_addr(nb_c, nb_r);
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      cgsrf_pkg::ST_BF_NBW: begin
        if (nb_join) begin
          cell_ctl.we = 1'b1;
          cell_waddr  = cell_addr(nb_c, nb_r);
          cell_wdata  = cell_rdata;
          cell_wdata[cgsrf_pkg::VIS_B] = 1'b1;
          q_ctl.we    = 1'b1;
          q_waddr     = tail_r[AW-1:0];
          q_wdata     = {nb_r, nb_c};
          tail_nxt    = tail_r + QW'(1);
        end
        dir_nxt = dir_r + 2'd1;
      end
      cgsrf_pkg::ST_MK_RD: begin
        if (idx_r < tail_r) begin
          q_ctl.re = 1'b1;
          q_raddr  = idx_r[AW-1:0];
          idx_nxt  = idx_r + QW'(1);
        end else if (!last_r) begin
          r_nxt = r_r + RW'(1);
        end else if (!last_c) begin
          r_nxt = RW'(1);
          c_nxt = c_r + CW'(1);
        end else begin
          sw_nxt = '0; pend_nxt = 1'b0;
        end
      end
      cgsrf_pkg::ST_MK_CELL: begin
        pc_nxt      = q_rdata[CW-1:0];
        pr_nxt      = q_rdata[RW+CW-1:CW];
        cell_ctl.re = 1'b1;
        cell_raddr  = cell_addr(q_rdata[CW-1:0], q_rdata[RW+CW-1:CW]);
      end
      cgsrf_pkg::ST_MK_WR: begin
        cell_ctl.we = 1'b1;
        cell_waddr  = cell_addr(pc_r, pr_r);
        cell_wdata  = cell_rdata;
        cell_wdata[cgsrf_pkg::FLIP_B] = 1'b1;
      end
      cgsrf_pkg::ST_APPLY: begin
        // Read one entry ahead and write the previous one back, its grid bit flipped
        // where its flip bit is set, with its visited and flip bits cleared for the next run.
        if (sw_r < QW'(CELLS)) begin
          cell_ctl.re = 1'b1;
          cell_raddr  = sw_r[AW-1:0];
          wa_nxt      = sw_r[AW-1:0];
          sw_nxt      = sw_r + QW'(1);
        end
        pend_nxt = (sw_r < QW'(CELLS));
        if (pend_r) begin
          cell_ctl.we = 1'b1;
          cell_waddr  = wa_r;
          cell_wdata[cgsrf_pkg::GRID_B] = cell_rdata[cgsrf_pkg::GRID_B] ^
                                          cell_rdata[cgsrf_pkg::FLIP_B];
        end
      end
      cgsrf_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = 1'b0;
          out_done_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgsrf_pkg::ST_CLEAR;
      sw_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;       r_r <= r_nxt;       pc_r <= pc_nxt;    pr_r <= pr_nxt;
    pass_r <= pass_nxt; ni_r <= ni_nxt;     cnt_r <= cnt_nxt;  val_r <= val_nxt;
    rd_in_r <= rd_in_nxt; dir_r <= dir_nxt;
    head_r <= head_nxt; tail_r <= tail_nxt; idx_r <= idx_nxt;  wa_r <= wa_nxt;
    out_cell_r <= out_cell_nxt; out_done_r <= out_done_nxt;
  end

  assign in_stall     = (state_r != cgsrf_pkg::ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_cell_out = out_cell_r;
  assign out_run_done = out_done_r;

endmodule

/* design/cgsrf_checker.sv */
`timescale 1ns / 1ps
`include "cave_grid_smooth_and_region_filter_defines.svh"
module cgsrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_op,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_cell_out,
  input logic       out_run_done
);

  // The memory clearing pass holds off input right after reset.
  `CGSRF_ASSERT_NOW(a_clear_after_reset, !$past(rst_n), in_stall)
  // A run answer never carries a cell value.
  `CGSRF_ASSERT_NOW(a_run_cell_zero, out_valid && out_run_done, !out_cell_out)
  // A run keeps the input side busy at least for the following cycle.
  `CGSRF_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && in_op == cgsrf_pkg::OP_RUN,
                     in_stall)
  // A stalled result stays offered.
  `CGSRF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind cave_grid_smooth_and_region_filter cgsrf_checker u_cgsrf_checker (.*);
